>>> hdl/fbf_pkg.sv
package fbf_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 8;

  localparam logic [CfgIndexWidth-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_SYNC_SECOND = 2'd1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DROP  = 2'd1;
  localparam logic [1:0] ST_ABORT = 2'd2;

  localparam logic [2:0] STEP_SYNC0 = 3'd0;
  localparam logic [2:0] STEP_SYNC1 = 3'd1;
  localparam logic [2:0] STEP_CLASS = 3'd2;
  localparam logic [2:0] STEP_ID    = 3'd3;
  localparam logic [2:0] STEP_LEN0  = 3'd4;
  localparam logic [2:0] STEP_LEN1  = 3'd5;
  localparam logic [2:0] STEP_CKA   = 3'd6;
  localparam logic [2:0] STEP_CKB   = 3'd7;

  typedef struct packed {
    logic        frame_start;
    logic [7:0]  msg_kind;
    logic [7:0]  msg_id;
    logic [15:0] body_len;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_frame;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
  } cfg_t;

  typedef struct packed {
    logic        hdr;
    logic        close;
    logic [1:0]  status;
    logic [7:0]  msg_kind;
    logic [7:0]  msg_id;
    logic [15:0] len;
    logic [7:0]  pbyte;
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
  } cmd_t;

endpackage

>>> hdl/fbf_front.sv
module fbf_front
  import fbf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t item,
  output cmd_t     cmd
);

  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [15:0] bytes_left;
  logic        frame_open;

  logic [7:0]  sum_a_next;
  logic [7:0]  sum_b_next;
  logic [15:0] bytes_left_next;
  logic        frame_open_next;

  logic [7:0] ha1, ha2, ha3, ha4, hb2, hb3, hb4;
  logic [7:0] pa, pb;

  always_comb begin
    ha1 = item.msg_kind;
    ha2 = ha1 + item.msg_id;
    hb2 = ha1 + ha2;
    ha3 = ha2 + item.body_len[7:0];
    hb3 = hb2 + ha3;
    ha4 = ha3 + item.body_len[15:8];
    hb4 = hb3 + ha4;
    pa  = sum_a + item.payload_byte;
    pb  = sum_b + pa;
  end

  always_comb begin
    sum_a_next      = sum_a;
    sum_b_next      = sum_b;
    bytes_left_next = bytes_left;
    frame_open_next = frame_open;
    cmd.hdr         = item.frame_start;
    cmd.close       = 1'b0;
    cmd.status      = ST_OK;
    cmd.msg_kind    = item.msg_kind;
    cmd.msg_id      = item.msg_id;
    cmd.len         = item.body_len;
    cmd.pbyte       = item.payload_byte;
    cmd.ck_a        = pa;
    cmd.ck_b        = pb;
    priority if (item.frame_start) begin
      cmd.status      = frame_open ? ST_ABORT : ST_OK;
      cmd.close       = (item.body_len == 16'd0);
      cmd.ck_a        = ha4;
      cmd.ck_b        = hb4;
      sum_a_next      = ha4;
      sum_b_next      = hb4;
      bytes_left_next = item.body_len;
      frame_open_next = (item.body_len != 16'd0);
    end else if (!frame_open) begin
      cmd.status = ST_DROP;
      cmd.pbyte  = 8'd0;
    end else begin
      cmd.close       = (bytes_left == 16'd1);
      sum_a_next      = pa;
      sum_b_next      = pb;
      bytes_left_next = bytes_left - 16'd1;
      frame_open_next = (bytes_left != 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a      <= 8'd0;
      sum_b      <= 8'd0;
      bytes_left <= 16'd0;
      frame_open <= 1'b0;
    end else if (accept) begin
      sum_a      <= sum_a_next;
      sum_b      <= sum_b_next;
      bytes_left <= bytes_left_next;
      frame_open <= frame_open_next;
    end
  end

endmodule

>>> hdl/fbf_queue.sv
module fbf_queue
  import fbf_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);

  cmd_t                mem [Depth];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;

  assign full       = (count == CntWidth'(Depth));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/fbf_back.sv
module fbf_back
  import fbf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      head_valid,
  input  cmd_t      head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic       started;
  logic [2:0] step;
  logic [2:0] cur_step;
  logic       emit;
  logic       last;
  out_item_t  res;

  assign cur_step = started ? step : (head.hdr ? STEP_SYNC0 : STEP_LEN1);
  assign emit     = head_valid && (!out_valid || out_ready);
  assign last     = head.close ? (cur_step == STEP_CKB) : (cur_step == STEP_LEN1);
  assign pop      = emit && last;

  always_comb begin
    unique case (cur_step)
      STEP_SYNC0: res.out_byte = cfg.sync_first;
      STEP_SYNC1: res.out_byte = cfg.sync_second;
      STEP_CLASS: res.out_byte = head.msg_kind;
      STEP_ID:    res.out_byte = head.msg_id;
      STEP_LEN0:  res.out_byte = head.len[7:0];
      STEP_LEN1:  res.out_byte = head.hdr ? head.len[15:8] : head.pbyte;
      STEP_CKA:   res.out_byte = head.ck_a;
      STEP_CKB:   res.out_byte = head.ck_b;
    endcase
    res.end_of_run   = last;
    res.end_of_frame = (cur_step == STEP_CKB);
    res.status       = head.status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      step      <= STEP_SYNC0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        started <= !last;
        step    <= cur_step + 3'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= res;
    end
  end

endmodule

>>> hdl/binary_frame_builder_fletcher8_core.sv
// Binary frame builder with an 8-bit Fletcher checksum.
// Input channel (in_valid/in_ready/in_data): a header request (frame_start = 1)
// opens a frame and yields sync bytes, class, id and length low/high; each
// payload request yields its byte. After the last payload byte, or straight
// after a header with zero length, CK_A and CK_B follow and close the frame.
// Output channel (out_valid/out_ready/out_data) carries one byte per transfer.
// The first byte of a request passes through the command queue and then the
// output register. Payload requests pass at one per cycle while the receiver
// is ready; a header yields 6 output bytes (8 with an empty payload) and a
// closing payload byte yields 3. The front end classifies and updates the
// checksum at accept time; a command queue of QueueDepth entries lets it run
// ahead while the back end serializes. in_ready drops only when it is full.
// When the receiver stalls, the output register holds and the queue fills.
// Reset clears the checksum, open-frame state, queue and output valid, and
// restores the sync bytes to 0xB5 and 0x62. cfg_we writes sync_first (index
// 0) or sync_second (index 1); other indexes are ignored.
module binary_frame_builder_fletcher8_core
  import fbf_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  cmd_t head;
  logic full;
  logic head_valid;
  logic pop;
  logic accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= 8'd181;
      cfg.sync_second <= 8'd98;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SYNC_FIRST) begin
        cfg.sync_first <= cfg_data;
      end else if (cfg_index == CFG_SYNC_SECOND) begin
        cfg.sync_second <= cfg_data;
      end
    end
  end

  fbf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_data),
    .cmd    (cmd)
  );

  fbf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  fbf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_data)
  );

endmodule
